@@ src/cau_pkg.sv @@
package cau_pkg;

    localparam int OP_W  = 3;
    localparam int EXP_W = 5;
    localparam int E_W   = EXP_W - 1;
    localparam int ST_W  = 2;
    localparam int STEP_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_SUM  = 3'd0,
        OP_DIFF = 3'd1,
        OP_PROD = 3'd2,
        OP_QUOT = 3'd3,
        OP_MAG  = 3'd4,
        OP_POW  = 3'd5
    } opcode_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_DIV0   = 2'd1,
        ST_BADEXP = 2'd2,
        ST_OVF    = 2'd3
    } status_t;

    // operand pair fed to the shared multiplier
    typedef enum logic [3:0] {
        MP_XR_YR,
        MP_XI_YI,
        MP_XR_YI,
        MP_XI_YR,
        MP_YR_YR,
        MP_YI_YI,
        MP_YR_YI,
        MP_XR_XR,
        MP_XI_XI
    } mpair_t;

    // what happens to the product in the cycle after its multiply command
    typedef enum logic [3:0] {
        ACC_NONE,
        ACC_RE_LOAD,
        ACC_RE_ADD,
        ACC_RE_SUB,
        ACC_IM_LOAD,
        ACC_IM_LOADNEG,
        ACC_IM_ADD,
        ACC_SQ_LOAD,
        ACC_SQ_ADD
    } accop_t;

    typedef enum logic [1:0] {
        MS_CP_X,
        MS_CP_Y,
        MS_QUOT,
        MS_MAG
    } mseq_t;

    typedef enum logic [3:0] {
        CMD_IDLE,
        CMD_LOAD,
        CMD_ADD,
        CMD_SUB,
        CMD_ZERO,
        CMD_POW_INIT,
        CMD_MUL,
        CMD_RND_X,
        CMD_RND_Y,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_DIV_WR,
        CMD_SQ_INIT,
        CMD_SQ_STEP,
        CMD_SQ_WR
    } dcmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_MUL,
        S_MWAIT,
        S_RND,
        S_DCHK,
        S_DIV,
        S_DIVWR,
        S_SQINIT,
        S_SQ,
        S_SQWR,
        S_PLOOP,
        S_PSHIFT,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        dcmd_t  cmd;
        mpair_t pair;
        accop_t acc;
    } dp_cmd_t;

    typedef struct packed {
        logic ovf;
        logic den_zero;
    } dp_stat_t;

    typedef struct packed {
        mpair_t pair;
        accop_t acc;
        logic   last;
    } mul_entry_t;

    // multiply schedule for each sequence
    function automatic mul_entry_t mul_entry(input mseq_t m, input logic [STEP_W-1:0] step);
        mul_entry_t e;
        e = '{pair: MP_XR_YR, acc: ACC_NONE, last: 1'b1};
        case (m)
            MS_CP_X:
            begin
                case (step)
                    3'd0: e = '{MP_XR_YR, ACC_RE_LOAD, 1'b0};
                    3'd1: e = '{MP_XI_YI, ACC_RE_SUB,  1'b0};
                    3'd2: e = '{MP_XR_YI, ACC_IM_LOAD, 1'b0};
                    default: e = '{MP_XI_YR, ACC_IM_ADD, 1'b1};
                endcase
            end
            MS_CP_Y:
            begin
                case (step)
                    3'd0: e = '{MP_YR_YR, ACC_RE_LOAD, 1'b0};
                    3'd1: e = '{MP_YI_YI, ACC_RE_SUB,  1'b0};
                    3'd2: e = '{MP_YR_YI, ACC_IM_LOAD, 1'b0};
                    default: e = '{MP_YR_YI, ACC_IM_ADD, 1'b1};
                endcase
            end
            MS_QUOT:
            begin
                case (step)
                    3'd0: e = '{MP_XR_YR, ACC_RE_LOAD,    1'b0};
                    3'd1: e = '{MP_XI_YI, ACC_RE_ADD,     1'b0};
                    3'd2: e = '{MP_XR_YI, ACC_IM_LOADNEG, 1'b0};
                    3'd3: e = '{MP_XI_YR, ACC_IM_ADD,     1'b0};
                    3'd4: e = '{MP_YR_YR, ACC_SQ_LOAD,    1'b0};
                    default: e = '{MP_YI_YI, ACC_SQ_ADD,  1'b1};
                endcase
            end
            default:
            begin
                case (step)
                    3'd0: e = '{MP_XR_XR, ACC_SQ_LOAD, 1'b0};
                    default: e = '{MP_XI_XI, ACC_SQ_ADD, 1'b1};
                endcase
            end
        endcase
        return e;
    endfunction

endpackage

@@ src/cau_dp.sv @@
module cau_dp #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cau_pkg::dp_cmd_t      cmd,
    input  logic signed [W-1:0]   a_re,
    input  logic signed [W-1:0]   a_im,
    input  logic signed [W-1:0]   b_re,
    input  logic signed [W-1:0]   b_im,
    output cau_pkg::dp_stat_t     stat,
    output logic signed [W-1:0]   res_re,
    output logic signed [W-1:0]   res_im
);
    import cau_pkg::*;

    localparam int ACC_W = 2 * W + 2;
    localparam int P_W   = 2 * W;
    localparam int DEN_W = 2 * W + 1;
    localparam int REM_W = 2 * W + 2;
    localparam int SR_W  = W + 3;
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    // saturate a sign-magnitude value to the word, top bit flags overflow
    function automatic logic [W:0] sat_mag(input logic neg, input logic [ACC_W-1:0] mag);
        logic [ACC_W-1:0] lim;
        logic [ACC_W-1:0] nmag;
        logic [W:0]       r;
        lim  = ACC_W'(1) << (W - 1);
        nmag = -mag;
        if (neg)
        begin
            if (mag > lim)
                r = {1'b1, MINV};
            else
                r = {1'b0, nmag[W-1:0]};
        end
        else
        begin
            if (mag >= lim)
                r = {1'b1, MAXV};
            else
                r = {1'b0, mag[W-1:0]};
        end
        return r;
    endfunction

    // round half away from zero, drop the fraction bits, saturate
    function automatic logic [W:0] rnd_sat(input logic signed [ACC_W-1:0] v);
        logic             neg;
        logic [ACC_W-1:0] m;
        logic [ACC_W-1:0] t;
        neg = v[ACC_W-1];
        m   = neg ? ACC_W'(-v) : ACC_W'(v);
        t   = (m + (ACC_W'(1) << (F - 1))) >> F;
        return sat_mag(neg, t);
    endfunction

    function automatic logic [W:0] add_sat(input logic signed [W:0] s);
        logic [W:0] m;
        m = s[W] ? (~s + 1'b1) : s;
        return sat_mag(s[W], ACC_W'(m));
    endfunction

    logic signed [W-1:0]     x_re_reg, x_im_reg, y_re_reg, y_im_reg;
    logic signed [W-1:0]     x_re_next, x_im_next, y_re_next, y_im_next;
    logic signed [W-1:0]     mul_a, mul_b;
    logic signed [P_W-1:0]   prod_reg, prod_next;
    accop_t                  acc_op_reg, acc_op_next;
    logic signed [ACC_W-1:0] acc_re_reg, acc_re_next, acc_im_reg, acc_im_next, prod_ext;
    logic [DEN_W-1:0]        acc_sq_reg, acc_sq_next;
    logic                    ovf_reg, ovf_next;

    logic [P_W-1:0]          dvd_re_reg, dvd_re_next, dvd_im_reg, dvd_im_next;
    logic [REM_W-1:0]        rem_re_reg, rem_re_next, rem_im_reg, rem_im_next;
    logic [REM_W-1:0]        rsh_re, rsh_im, den_ext;
    logic [W-1:0]            q_re_reg, q_re_next, q_im_reg, q_im_next;
    logic                    big_re_reg, big_re_next, big_im_reg, big_im_next;
    logic                    neg_re_reg, neg_re_next, neg_im_reg, neg_im_next;

    logic [P_W-1:0]          rad_reg, rad_next;
    logic [SR_W-1:0]         srem_reg, srem_next, srem_sh, trial;
    logic [W-1:0]            root_reg, root_next;

    logic [W:0]              r_a, r_b;
    logic [ACC_W-1:0]        mag_re, mag_im;

    always_comb
    begin
        case (cmd.pair)
            MP_XR_YR: begin mul_a = x_re_reg; mul_b = y_re_reg; end
            MP_XI_YI: begin mul_a = x_im_reg; mul_b = y_im_reg; end
            MP_XR_YI: begin mul_a = x_re_reg; mul_b = y_im_reg; end
            MP_XI_YR: begin mul_a = x_im_reg; mul_b = y_re_reg; end
            MP_YR_YR: begin mul_a = y_re_reg; mul_b = y_re_reg; end
            MP_YI_YI: begin mul_a = y_im_reg; mul_b = y_im_reg; end
            MP_YR_YI: begin mul_a = y_re_reg; mul_b = y_im_reg; end
            MP_XR_XR: begin mul_a = x_re_reg; mul_b = x_re_reg; end
            default:  begin mul_a = x_im_reg; mul_b = x_im_reg; end
        endcase
    end

    assign prod_next   = mul_a * mul_b;
    assign acc_op_next = (cmd.cmd == CMD_MUL) ? cmd.acc : ACC_NONE;
    assign prod_ext    = ACC_W'(prod_reg);
    assign den_ext     = REM_W'(acc_sq_reg);
    assign rsh_re      = {rem_re_reg[REM_W-2:0], dvd_re_reg[P_W-1]};
    assign rsh_im      = {rem_im_reg[REM_W-2:0], dvd_im_reg[P_W-1]};
    assign srem_sh     = {srem_reg[SR_W-3:0], rad_reg[P_W-1:P_W-2]};
    assign trial       = {1'b0, root_reg, 2'b01};
    assign mag_re      = acc_re_reg[ACC_W-1] ? ACC_W'(-acc_re_reg) : ACC_W'(acc_re_reg);
    assign mag_im      = acc_im_reg[ACC_W-1] ? ACC_W'(-acc_im_reg) : ACC_W'(acc_im_reg);

    // product accumulation, from the registered product in the cycle after the multiply
    always_comb
    begin
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        acc_sq_next = acc_sq_reg;
        case (acc_op_reg)
            ACC_RE_LOAD:    acc_re_next = prod_ext;
            ACC_RE_ADD:     acc_re_next = acc_re_reg + prod_ext;
            ACC_RE_SUB:     acc_re_next = acc_re_reg - prod_ext;
            ACC_IM_LOAD:    acc_im_next = prod_ext;
            ACC_IM_LOADNEG: acc_im_next = -prod_ext;
            ACC_IM_ADD:     acc_im_next = acc_im_reg + prod_ext;
            ACC_SQ_LOAD:    acc_sq_next = DEN_W'(unsigned'(prod_reg));
            ACC_SQ_ADD:     acc_sq_next = acc_sq_reg + DEN_W'(unsigned'(prod_reg));
            default:        ;
        endcase
    end

    always_comb
    begin
        x_re_next   = x_re_reg;
        x_im_next   = x_im_reg;
        y_re_next   = y_re_reg;
        y_im_next   = y_im_reg;
        ovf_next    = ovf_reg;
        dvd_re_next = dvd_re_reg;
        dvd_im_next = dvd_im_reg;
        rem_re_next = rem_re_reg;
        rem_im_next = rem_im_reg;
        q_re_next   = q_re_reg;
        q_im_next   = q_im_reg;
        big_re_next = big_re_reg;
        big_im_next = big_im_reg;
        neg_re_next = neg_re_reg;
        neg_im_next = neg_im_reg;
        rad_next    = rad_reg;
        srem_next   = srem_reg;
        root_next   = root_reg;
        r_a         = '0;
        r_b         = '0;
        case (cmd.cmd)
            CMD_LOAD:
            begin
                x_re_next = a_re;
                x_im_next = a_im;
                y_re_next = b_re;
                y_im_next = b_im;
                ovf_next  = 1'b0;
            end
            CMD_ADD, CMD_SUB:
            begin
                if (cmd.cmd == CMD_ADD)
                begin
                    r_a = add_sat((W+1)'(x_re_reg) + (W+1)'(y_re_reg));
                    r_b = add_sat((W+1)'(x_im_reg) + (W+1)'(y_im_reg));
                end
                else
                begin
                    r_a = add_sat((W+1)'(x_re_reg) - (W+1)'(y_re_reg));
                    r_b = add_sat((W+1)'(x_im_reg) - (W+1)'(y_im_reg));
                end
                x_re_next = r_a[W-1:0];
                x_im_next = r_b[W-1:0];
                ovf_next  = ovf_reg | r_a[W] | r_b[W];
            end
            CMD_ZERO:
            begin
                x_re_next = '0;
                x_im_next = '0;
            end
            CMD_POW_INIT:
            begin
                r_a       = sat_mag(1'b0, ACC_W'(1) << F);
                y_re_next = x_re_reg;
                y_im_next = x_im_reg;
                x_re_next = r_a[W-1:0];
                x_im_next = '0;
                ovf_next  = ovf_reg | r_a[W];
            end
            CMD_RND_X, CMD_RND_Y:
            begin
                r_a      = rnd_sat(acc_re_reg);
                r_b      = rnd_sat(acc_im_reg);
                ovf_next = ovf_reg | r_a[W] | r_b[W];
                if (cmd.cmd == CMD_RND_X)
                begin
                    x_re_next = r_a[W-1:0];
                    x_im_next = r_b[W-1:0];
                end
                else
                begin
                    y_re_next = r_a[W-1:0];
                    y_im_next = r_b[W-1:0];
                end
            end
            CMD_DIV_INIT:
            begin
                dvd_re_next = mag_re[P_W-1:0];
                dvd_im_next = mag_im[P_W-1:0];
                neg_re_next = acc_re_reg[ACC_W-1];
                neg_im_next = acc_im_reg[ACC_W-1];
                rem_re_next = '0;
                rem_im_next = '0;
                q_re_next   = '0;
                q_im_next   = '0;
                big_re_next = 1'b0;
                big_im_next = 1'b0;
            end
            CMD_DIV_STEP:
            begin
                dvd_re_next = dvd_re_reg << 1;
                dvd_im_next = dvd_im_reg << 1;
                big_re_next = big_re_reg | q_re_reg[W-1];
                big_im_next = big_im_reg | q_im_reg[W-1];
                q_re_next   = {q_re_reg[W-2:0], rsh_re >= den_ext};
                q_im_next   = {q_im_reg[W-2:0], rsh_im >= den_ext};
                rem_re_next = (rsh_re >= den_ext) ? rsh_re - den_ext : rsh_re;
                rem_im_next = (rsh_im >= den_ext) ? rsh_im - den_ext : rsh_im;
            end
            CMD_DIV_WR:
            begin
                r_a       = sat_mag(neg_re_reg, ACC_W'({big_re_reg, q_re_reg}));
                r_b       = sat_mag(neg_im_reg, ACC_W'({big_im_reg, q_im_reg}));
                x_re_next = r_a[W-1:0];
                x_im_next = r_b[W-1:0];
                ovf_next  = ovf_reg | r_a[W] | r_b[W];
            end
            CMD_SQ_INIT:
            begin
                rad_next  = acc_sq_reg[P_W-1:0];
                srem_next = '0;
                root_next = '0;
            end
            CMD_SQ_STEP:
            begin
                rad_next  = rad_reg << 2;
                srem_next = (srem_sh >= trial) ? srem_sh - trial : srem_sh;
                root_next = {root_reg[W-2:0], srem_sh >= trial};
            end
            CMD_SQ_WR:
            begin
                r_a       = sat_mag(1'b0, ACC_W'(root_reg));
                x_re_next = r_a[W-1:0];
                x_im_next = '0;
                ovf_next  = ovf_reg | r_a[W];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_op_reg <= ACC_NONE;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            acc_op_reg <= acc_op_next;
            ovf_reg    <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_re_reg   <= x_re_next;
        x_im_reg   <= x_im_next;
        y_re_reg   <= y_re_next;
        y_im_reg   <= y_im_next;
        prod_reg   <= prod_next;
        acc_re_reg <= acc_re_next;
        acc_im_reg <= acc_im_next;
        acc_sq_reg <= acc_sq_next;
        dvd_re_reg <= dvd_re_next;
        dvd_im_reg <= dvd_im_next;
        rem_re_reg <= rem_re_next;
        rem_im_reg <= rem_im_next;
        q_re_reg   <= q_re_next;
        q_im_reg   <= q_im_next;
        big_re_reg <= big_re_next;
        big_im_reg <= big_im_next;
        neg_re_reg <= neg_re_next;
        neg_im_reg <= neg_im_next;
        rad_reg    <= rad_next;
        srem_reg   <= srem_next;
        root_reg   <= root_next;
    end

    assign stat.ovf      = ovf_reg;
    assign stat.den_zero = (acc_sq_reg == '0);
    assign res_re        = x_re_reg;
    assign res_im        = x_im_reg;

endmodule

@@ src/cau_ctrl.sv @@
module cau_ctrl #(
    parameter int W       = 32,
    parameter int F       = 16,
    parameter int EXP_MAX = 15
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cau_pkg::OP_W-1:0]      req_type,
    input  logic [cau_pkg::EXP_W-1:0]     exponent,
    input  cau_pkg::dp_stat_t             stat,
    output cau_pkg::dp_cmd_t              cmd,
    output logic                          busy,
    output logic                          done,
    output logic [cau_pkg::ST_W-1:0]      status
);
    import cau_pkg::*;

    localparam int DIV_STEPS = 2 * W + F;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    ctrl_state_t         state_reg, state_next;
    opcode_t             op_reg, op_next;
    logic [EXP_W-1:0]    exp_reg, exp_next;
    logic [E_W-1:0]      e_reg, e_next;
    mseq_t               mseq_reg, mseq_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    status_t             st_reg, st_next;
    logic                done_reg, done_next;
    status_t             status_reg, status_next;
    mul_entry_t          ment;
    logic                exp_bad;

    assign ment    = mul_entry(mseq_reg, step_reg);
    assign exp_bad = exp_reg[EXP_W-1] || (32'(exp_reg[E_W-1:0]) > 32'(EXP_MAX));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= OP_SUM;
            exp_reg    <= '0;
            e_reg      <= '0;
            mseq_reg   <= MS_CP_X;
            step_reg   <= '0;
            cnt_reg    <= '0;
            st_reg     <= ST_OK;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            exp_reg    <= exp_next;
            e_reg      <= e_next;
            mseq_reg   <= mseq_next;
            step_reg   <= step_next;
            cnt_reg    <= cnt_next;
            st_reg     <= st_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        exp_next    = exp_reg;
        e_next      = e_reg;
        mseq_next   = mseq_reg;
        step_next   = step_reg;
        cnt_next    = cnt_reg;
        st_next     = st_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        cmd         = '{cmd: CMD_IDLE, pair: MP_XR_YR, acc: ACC_NONE};
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = opcode_t'(req_type);
                    exp_next   = exponent;
                    st_next    = ST_OK;
                    cmd.cmd    = CMD_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                step_next = '0;
                case (op_reg)
                    OP_SUM:
                    begin
                        cmd.cmd    = CMD_ADD;
                        state_next = S_FINISH;
                    end
                    OP_DIFF:
                    begin
                        cmd.cmd    = CMD_SUB;
                        state_next = S_FINISH;
                    end
                    OP_PROD:
                    begin
                        mseq_next  = MS_CP_X;
                        state_next = S_MUL;
                    end
                    OP_QUOT:
                    begin
                        mseq_next  = MS_QUOT;
                        state_next = S_MUL;
                    end
                    OP_MAG:
                    begin
                        mseq_next  = MS_MAG;
                        state_next = S_MUL;
                    end
                    OP_POW:
                    begin
                        if (exp_bad)
                        begin
                            cmd.cmd    = CMD_ZERO;
                            st_next    = ST_BADEXP;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.cmd    = CMD_POW_INIT;
                            e_next     = exp_reg[E_W-1:0];
                            state_next = S_PLOOP;
                        end
                    end
                    default:
                    begin
                        cmd.cmd    = CMD_ZERO;
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_MUL:
            begin
                cmd.cmd   = CMD_MUL;
                cmd.pair  = ment.pair;
                cmd.acc   = ment.acc;
                step_next = step_reg + 1'b1;
                if (ment.last)
                    state_next = S_MWAIT;
            end
            S_MWAIT:
            begin
                case (mseq_reg)
                    MS_QUOT: state_next = S_DCHK;
                    MS_MAG:  state_next = S_SQINIT;
                    default: state_next = S_RND;
                endcase
            end
            S_RND:
            begin
                if (mseq_reg == MS_CP_Y)
                begin
                    cmd.cmd    = CMD_RND_Y;
                    state_next = S_PLOOP;
                end
                else
                begin
                    cmd.cmd    = CMD_RND_X;
                    state_next = (op_reg == OP_POW) ? S_PSHIFT : S_FINISH;
                end
            end
            S_DCHK:
            begin
                if (stat.den_zero)
                begin
                    cmd.cmd    = CMD_ZERO;
                    st_next    = ST_DIV0;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.cmd    = CMD_DIV_INIT;
                    cnt_next   = CNT_W'(DIV_STEPS - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.cmd  = CMD_DIV_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_DIVWR;
            end
            S_DIVWR:
            begin
                cmd.cmd    = CMD_DIV_WR;
                state_next = S_FINISH;
            end
            S_SQINIT:
            begin
                cmd.cmd    = CMD_SQ_INIT;
                cnt_next   = CNT_W'(W - 1);
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.cmd  = CMD_SQ_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_SQWR;
            end
            S_SQWR:
            begin
                cmd.cmd    = CMD_SQ_WR;
                state_next = S_FINISH;
            end
            S_PLOOP:
            begin
                step_next = '0;
                if (e_reg == '0)
                    state_next = S_FINISH;
                else if (e_reg[0])
                begin
                    mseq_next  = MS_CP_X;
                    state_next = S_MUL;
                end
                else
                    state_next = S_PSHIFT;
            end
            S_PSHIFT:
            begin
                step_next = '0;
                e_next    = e_reg >> 1;
                if ((e_reg >> 1) != '0)
                begin
                    mseq_next  = MS_CP_Y;
                    state_next = S_MUL;
                end
                else
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                done_next = 1'b1;
                if (st_reg != ST_OK)
                    status_next = st_reg;
                else
                    status_next = stat.ovf ? ST_OVF : ST_OK;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;

    // a result strobe always follows the final state of a transaction
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_FINISH))
        else $error("result strobe without a finished transaction");

    // an accepted transaction leaves idle on the next edge
    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && state_reg == S_IDLE) |=> (state_reg == S_DISPATCH))
        else $error("accepted transaction did not start");

    // exponent error is reported only for the power operation
    a_badexp_pow: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == ST_BADEXP) |-> (op_reg == OP_POW))
        else $error("exponent error on a non-power operation");

    // divide by zero is reported only for the quotient
    a_div0_quot: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == ST_DIV0) |-> (op_reg == OP_QUOT))
        else $error("divide by zero on a non-quotient operation");

endmodule

@@ src/complex_arithmetic_unit.sv @@
// complex arithmetic unit: add, subtract, multiply, divide, magnitude and
// integer power on two complex operands in signed fixed point
// (WORD_BITS wide, FRAC_BITS fraction bits)
// input channel: a transaction is accepted on the clock edge where start is
//   high and busy is low; req_type, operands and exponent are sampled there
// output channel: done is high for exactly one cycle with res_re, res_im and
//   status valid; the receiver cannot stall, so the result must be taken then
// one transaction at a time; the time from accept to done depends on the operation:
//   add/subtract, unused opcodes and a bad exponent go from dispatch straight to finish
//   multiply (four products on one shared multiplier, then round)
//   divide (two restoring dividers side by side,
//     one quotient bit per cycle), or an early zero result on a zero denominator
//   magnitude (digit-by-digit square root, one root bit per cycle)
//   power: square-and-multiply, one loop step per exponent bit, each multiply or
//     square followed by a round; exponent 0 goes straight to finish
// the shared multiplier and the iterative divide and root set how long each operation takes
// a new start is taken in the same cycle that done is shown
// reset (rst_n low, asynchronous) returns to idle with busy and done low
module complex_arithmetic_unit #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16,
    parameter int EXP_MAX   = 15
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cau_pkg::OP_W-1:0]      req_type,
    input  logic signed [WORD_BITS-1:0]   a_re,
    input  logic signed [WORD_BITS-1:0]   a_im,
    input  logic signed [WORD_BITS-1:0]   b_re,
    input  logic signed [WORD_BITS-1:0]   b_im,
    input  logic signed [cau_pkg::EXP_W-1:0] exponent,
    output logic                          done,
    output logic signed [WORD_BITS-1:0]   res_re,
    output logic signed [WORD_BITS-1:0]   res_im,
    output logic [cau_pkg::ST_W-1:0]      status
);
    import cau_pkg::*;

    // command and status between sequencer and datapath
    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    cau_ctrl #(
        .W       (WORD_BITS),
        .F       (FRAC_BITS),
        .EXP_MAX (EXP_MAX)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .exponent (exponent),
        .stat     (dp_stat),
        .cmd      (dp_cmd),
        .busy     (busy),
        .done     (done),
        .status   (status)
    );

    // operand registers, shared multiplier, accumulators, divider and root
    cau_dp #(
        .W (WORD_BITS),
        .F (FRAC_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (dp_cmd),
        .a_re   (a_re),
        .a_im   (a_im),
        .b_re   (b_re),
        .b_im   (b_im),
        .stat   (dp_stat),
        .res_re (res_re),
        .res_im (res_im)
    );

endmodule
